[design/fsh_pkg.sv]
// Shared types and constants for the serpentine error-diffusion halftoner.
package fsh_pkg;

    localparam int GRAY_BITS   = 8;
    localparam int INK_BITS    = 12;
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int ROW_BITS    = 12;
    localparam int TAG_BITS    = 12;
    localparam int MAX_HEIGHT  = 4096;
    localparam int FULL_SCALE  = 4080;
    localparam int HALF_SCALE  = 2040;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 13;
    localparam int DATA_BYTE_BITS = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]  seq;
        logic [GRAY_BITS-1:0] gray;
        logic                 bank;
        logic                 odd;
        logic                 first_row;
        logic                 row_end;
        logic                 img_end;
        logic                 has_next;
        logic                 can_back;
    } fsh_item_t;

endpackage

[design/fsh_ram.sv]
// Generic simple dual-port RAM with registered read.
module fsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/fsh_queue.sv]
// Short item queue between the front and back parts.
module fsh_queue
    import fsh_pkg::*;
#(
    parameter int WIDTH = 32
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |-> pop == 1'b0 && push == 1'b0)
        else $error("push into full queue");

endmodule

[design/fsh_front.sv]
// Front part: takes pixels, tracks the serpentine position and tags each item.
module fsh_front
    import fsh_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [WIDTH_BITS-1:0]        image_width,
    input  logic [HEIGHT_BITS-1:0]       image_height,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [GRAY_BITS-1:0]         s_tdata,
    input  logic                         q_full,
    output logic                         q_push,
    output logic [$clog2(MAX_WIDTH)-1:0] q_x,
    output fsh_item_t                    q_item
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (AW + 1 > WIDTH_BITS) ? AW + 1 : WIDTH_BITS;

    logic [AW-1:0]          column_count_reg, column_count_next;
    logic [ROW_BITS-1:0]    row_count_reg, row_count_next;
    logic [TAG_BITS-1:0]    seq_reg, seq_next;
    logic                   buffer_select_reg, buffer_select_next;

    logic [WW-1:0]          width_ext, width_lim;
    logic [HEIGHT_BITS-1:0] height_lim;
    logic [AW-1:0]          last_col, col, x;
    logic [ROW_BITS-1:0]    last_row, row;
    logic                   odd, row_end, img_end, has_next, accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept;

    always_comb
    begin
        width_ext = WW'(image_width);
        if (width_ext == '0)
            width_lim = WW'(1);
        else if (width_ext > WW'(MAX_WIDTH))
            width_lim = WW'(MAX_WIDTH);
        else
            width_lim = width_ext;

        if (image_height == '0)
            height_lim = HEIGHT_BITS'(1);
        else if (image_height > HEIGHT_BITS'(MAX_HEIGHT))
            height_lim = HEIGHT_BITS'(MAX_HEIGHT);
        else
            height_lim = image_height;

        last_col = AW'(width_lim - WW'(1));
        last_row = ROW_BITS'(height_lim - HEIGHT_BITS'(1));
        col = (WW'(column_count_reg) < width_lim) ? column_count_reg : last_col;
        row = (HEIGHT_BITS'(row_count_reg) < height_lim) ? row_count_reg : last_row;

        odd      = row_count_reg[0];
        x        = odd ? last_col - col : col;
        row_end  = (col == last_col);
        img_end  = row_end && (row == last_row);
        has_next = (row != last_row);
    end

    always_comb
    begin
        q_x              = x;
        q_item.seq       = seq_reg;
        q_item.gray      = s_tdata;
        q_item.bank      = buffer_select_reg;
        q_item.odd       = odd;
        q_item.first_row = (row_count_reg == '0);
        q_item.row_end   = row_end;
        q_item.img_end   = img_end;
        q_item.has_next  = has_next;
        q_item.can_back  = (col != '0);
    end

    always_comb
    begin
        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        seq_next           = seq_reg;
        buffer_select_next = buffer_select_reg;
        if (accept)
        begin
            if (row_end)
            begin
                column_count_next  = '0;
                row_count_next     = img_end ? '0 : row + ROW_BITS'(1);
                seq_next           = seq_reg + TAG_BITS'(1);
                buffer_select_next = !buffer_select_reg;
            end
            else
            begin
                column_count_next = col + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            seq_reg           <= '0;
            buffer_select_reg <= 1'b0;
        end
        else
        begin
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
            seq_reg           <= seq_next;
            buffer_select_reg <= buffer_select_next;
        end
    end

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_end) |=> column_count_reg == '0 && $changed(buffer_select_reg))
        else $error("row end did not restart the column");

endmodule

[design/fsh_back.sv]
// Back part: error-row banks, threshold, diffusion window and output register.
module fsh_back
    import fsh_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int ERROR_BITS = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] q_x,
    input  fsh_item_t                    q_item,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [DATA_BYTE_BITS-1:0]    m_tdata,
    output logic                         m_tlast
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EB = ERROR_BITS;
    localparam int RW = EB + TAG_BITS;
    localparam logic signed [EB-1:0]   HALF_E = EB'(HALF_SCALE);
    localparam logic signed [EB+1:0]   FULL_E = (EB + 2)'(FULL_SCALE);

    function automatic logic signed [EB-1:0] sat_err(input logic signed [EB+1:0] v);
        logic signed [EB+1:0] hi;
        logic signed [EB+1:0] lo;
        hi = (EB + 2)'((1 << (EB - 1)) - 1);
        lo = ~hi;
        if (v > hi)
            return hi[EB-1:0];
        else if (v < lo)
            return lo[EB-1:0];
        else
            return v[EB-1:0];
    endfunction

    logic                 b1_vld_reg;
    logic [AW-1:0]        b1_x_reg;
    fsh_item_t            b1_item_reg;
    logic                 out_vld_reg, out_dot_reg, out_last_reg;
    logic signed [EB-1:0] ahead_err_reg, m0_reg, m1_reg;
    logic                 edge_vld_reg;
    logic [AW-1:0]        edge_x_reg;
    logic [TAG_BITS-1:0]  edge_seq_reg;
    logic signed [EB-1:0] edge_err_reg;

    logic                 out_free, fire;
    logic [1:0]           rd_en, wr_en;
    logic [RW-1:0]        rd_data [2];
    logic [RW-1:0]        rd_word, wr_data;
    logic [AW-1:0]        wr_addr;
    logic                 wr_go;

    logic [TAG_BITS-1:0]  prev_seq;
    logic signed [EB-1:0] cur_err, sum, err;
    logic [INK_BITS-1:0]  ink;
    logic signed [EB+1:0] sum_wide, err_wide, nb_wide, nm_wide;
    logic                 dot, edge_hit;
    logic signed [EB+2:0] p1, p3, p5, p7;
    logic signed [EB+2:0] d1, d3, d5, d7;
    logic signed [EB-1:0] s1, s3, s5, s7, a1, a5, nb, nm;

    assign out_free = !out_vld_reg || m_tready;
    assign fire     = b1_vld_reg && out_free;
    assign q_pop    = q_valid && (!b1_vld_reg || fire);

    for (genvar k = 0; k < 2; k++)
    begin : g_bank
        assign rd_en[k] = q_pop && (q_item.bank == 1'(k));
        assign wr_en[k] = wr_go && (b1_item_reg.bank != 1'(k));

        fsh_ram #(
            .WIDTH (RW),
            .DEPTH (MAX_WIDTH)
        ) u_row_ram (
            .clk     (clk),
            .wr_en   (wr_en[k]),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_en   (rd_en[k]),
            .rd_addr (q_x),
            .rd_data (rd_data[k])
        );
    end

    always_comb
    begin
        rd_word  = b1_item_reg.bank ? rd_data[1] : rd_data[0];
        prev_seq = b1_item_reg.seq - TAG_BITS'(1);
        edge_hit = edge_vld_reg && (edge_x_reg == b1_x_reg) && (edge_seq_reg == prev_seq);
        if (b1_item_reg.first_row)
            cur_err = '0;
        else if (edge_hit)
            cur_err = edge_err_reg;
        else if (rd_word[RW-1:EB] == prev_seq)
            cur_err = rd_word[EB-1:0];
        else
            cur_err = '0;

        ink      = {~b1_item_reg.gray, 4'b0000};
        sum_wide = $signed({{(EB + 2 - INK_BITS){1'b0}}, ink})
                 + $signed({{2{cur_err[EB-1]}}, cur_err})
                 + $signed({{2{ahead_err_reg[EB-1]}}, ahead_err_reg});
        sum      = sat_err(sum_wide);
        dot      = (sum >= HALF_E);
        err_wide = $signed({{2{sum[EB-1]}}, sum}) - (dot ? FULL_E : '0);
        err      = sat_err(err_wide);

        p1 = $signed({{3{err[EB-1]}}, err});
        p3 = (p1 <<< 1) + p1;
        p5 = (p1 <<< 2) + p1;
        p7 = (p1 <<< 3) - p1;
        d1 = p1 >>> 4;
        d3 = p3 >>> 4;
        d5 = p5 >>> 4;
        d7 = p7 >>> 4;
        s1 = d1[EB-1:0];
        s3 = d3[EB-1:0];
        s5 = d5[EB-1:0];
        s7 = d7[EB-1:0];

        a1 = (b1_item_reg.has_next && !b1_item_reg.row_end) ? s1 : '0;
        a5 = b1_item_reg.has_next ? s5 : '0;

        nb_wide = $signed({{2{m1_reg[EB-1]}}, m1_reg}) + $signed({{2{s3[EB-1]}}, s3});
        nm_wide = $signed({{2{m0_reg[EB-1]}}, m0_reg}) + $signed({{2{a5[EB-1]}}, a5});
        nb      = sat_err(nb_wide);
        nm      = sat_err(nm_wide);

        wr_go   = fire && b1_item_reg.has_next && b1_item_reg.can_back;
        wr_addr = b1_item_reg.odd ? b1_x_reg + AW'(1) : b1_x_reg - AW'(1);
        wr_data = {b1_item_reg.seq, nb};
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_x_reg    <= q_x;
            b1_item_reg <= q_item;
        end
        if (fire)
        begin
            out_dot_reg  <= dot;
            out_last_reg <= b1_item_reg.img_end;
        end
        if (fire && b1_item_reg.row_end && b1_item_reg.has_next)
        begin
            edge_x_reg   <= b1_x_reg;
            edge_seq_reg <= b1_item_reg.seq;
            edge_err_reg <= nm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            ahead_err_reg <= '0;
            m0_reg        <= '0;
            m1_reg        <= '0;
            edge_vld_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
                b1_vld_reg <= 1'b1;
            else if (fire)
                b1_vld_reg <= 1'b0;

            if (fire)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;

            if (fire)
            begin
                ahead_err_reg <= b1_item_reg.row_end ? '0 : s7;
                m1_reg        <= nm;
                m0_reg        <= a1;
                if (b1_item_reg.row_end && b1_item_reg.has_next)
                    edge_vld_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(DATA_BYTE_BITS - 1){1'b0}}, out_dot_reg};
    assign m_tlast  = out_last_reg;

    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && b1_item_reg.row_end) |=> ahead_err_reg == '0 && m0_reg == '0)
        else $error("diffusion window not cleared at row end");

    a_edge_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && b1_item_reg.row_end && b1_item_reg.has_next)
        |=> edge_vld_reg && edge_x_reg == $past(b1_x_reg))
        else $error("row edge error not captured");

    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        !((rd_en[0] && wr_en[0] && q_x == wr_addr) || (rd_en[1] && wr_en[1] && q_x == wr_addr)))
        else $error("read and write collide in one bank");

    a_write_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en != 2'b00) |-> fire && $onehot(wr_en))
        else $error("bank write outside an item");

endmodule

[design/floyd_steinberg_serpentine_halftone.sv]
// Top level of the Floyd-Steinberg serpentine halftoner.
//
//  port group   dir  handshake                 payload
//  s_*          in   s_tvalid / s_tready       s_tdata[7:0] = gray_pixel
//  m_*          out  m_tvalid / m_tready       m_tdata[0] = ink_dot, m_tlast = image_last
//  cfg_*        in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  One item per clock unless the output stalls; path: queue, b1, output register.
//  The per-pixel error recurrence closes in the back part through the ahead_err register.
//  Error rows live in two single-port-read RAM banks of MAX_WIDTH entries, tagged by row.
//  Reset clears position, window and handshake state; no clearing pass is needed.
//  A four-item queue lets input keep flowing while the output stalls, until it fills.
module floyd_steinberg_serpentine_halftone
    import fsh_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int ERROR_BITS = 16
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [GRAY_BITS-1:0]      s_tdata,     // [7:0] gray_pixel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [DATA_BYTE_BITS-1:0] m_tdata,     // [0] ink_dot, [7:1] zero
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QW = AW + $bits(fsh_item_t);

    logic [WIDTH_BITS-1:0]  image_width_reg;
    logic [HEIGHT_BITS-1:0] image_height_reg;

    logic          q_push, q_full, q_pop, q_valid;
    logic [AW-1:0] front_x, back_x;
    fsh_item_t     front_item, back_item;
    logic [QW-1:0] q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_BITS'(1024);
            image_height_reg <= HEIGHT_BITS'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    fsh_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_x          (front_x),
        .q_item       (front_item)
    );

    fsh_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({front_x, front_item}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_valid)
    );

    assign back_x    = q_out[QW-1:QW-AW];
    assign back_item = fsh_item_t'(q_out[QW-AW-1:0]);

    fsh_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .ERROR_BITS (ERROR_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_x      (back_x),
        .q_item   (back_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
